// ----- hw/rtl/tcst_pkg.sv -----
// Shared types and constants for the touch contact slot tracker.
// Used by tcst_cell, the core and the testbench.
package tcst_pkg;

   localparam int SLOT_W = 5;
   localparam int ID_W   = 64;
   localparam int OP_W   = 2;

   localparam logic [OP_W-1:0] OP_DOWN   = 2'd0;
   localparam logic [OP_W-1:0] OP_MOTION = 2'd1;
   localparam logic [OP_W-1:0] OP_UP     = 2'd2;
   localparam logic [OP_W-1:0] OP_CANCEL = 2'd3;

   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_ENABLE = 2'd2;

   // search token walking down the slot chain
   typedef struct packed {
      logic              valid;
      logic [OP_W-1:0]   op;
      logic [ID_W-1:0]   id;
      logic              hit;
      logic [SLOT_W-1:0] hit_idx;
      logic              free_seen;
      logic [SLOT_W-1:0] free_idx;
   } tok_type;

   // table update broadcast to every cell
   typedef struct packed {
      logic              en;
      logic              set;
      logic [SLOT_W-1:0] idx;
      logic [ID_W-1:0]   id;
   } wr_type;

endpackage

// ----- hw/rtl/touch_contact_slot_tracker_core.sv -----
// Touch contact slot tracker: top level with register port and slot chain.
// Depends on tcst_pkg, tcst_cell and tcst_scale.
//
// Usage: raise start with an event on the req_ ports; it is taken at a
// clock edge where start is high and busy is low. busy then stays high
// while a search token walks the row of MAX_TOUCHES slot cells, one cell
// per cycle. After the last cell the table update is broadcast to all
// cells and the result is registered: rsp_strobe is high for exactly one
// cycle, and busy drops in that same cycle. The next event can be taken
// at the edge that ends the strobe cycle, so events never overlap.
// The receiver has no way to stall; each result must be taken as shown.
// Window extents and the enable bit live in APB-style registers at byte
// addresses 0, 4 and 8; write them only while busy is low. When disabled
// an event still yields one result, all zero with rsp_accepted low.
// Reset (synchronous) frees every slot, clears the extents to zero and
// sets the enable bit.
module touch_contact_slot_tracker_core #(
   parameter int MAX_TOUCHES = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_opcode,
   input  logic [63:0]                 req_contact_id,
   input  logic [15:0]                 req_pos_x,
   input  logic [15:0]                 req_pos_y,
   input  logic signed [17:0]          req_delta_x,
   input  logic signed [17:0]          req_delta_y,
   output logic                        rsp_strobe,
   output logic                        rsp_accepted,
   output logic [1:0]                  rsp_event_kind,
   output logic                        rsp_slot_found,
   output logic [4:0]                  rsp_slot_index,
   output logic [13:0]                 rsp_abs_x,
   output logic [13:0]                 rsp_abs_y,
   output logic signed [15:0]          rsp_rel_x,
   output logic signed [15:0]          rsp_rel_y,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [3:0]                  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import tcst_pkg::*;

   logic [13:0]        width_ff;
   logic [13:0]        height_ff;
   logic               enable_ff;
   logic               csr_wr;
   logic               busy_ff;
   logic               accept;
   tok_type            tok_chain [0:MAX_TOUCHES];
   tok_type            tail;
   wr_type             wr;
   logic [13:0]        abs_x;
   logic [13:0]        abs_y;
   logic signed [15:0] rel_x;
   logic signed [15:0] rel_y;
   logic               found;
   logic [SLOT_W-1:0]  slot;

   logic               strobe_ff;
   logic               accepted_ff;
   logic [1:0]         kind_ff;
   logic               found_ff;
   logic [4:0]         slot_ff;
   logic [13:0]        abs_x_ff;
   logic [13:0]        abs_y_ff;
   logic signed [15:0] rel_x_ff;
   logic signed [15:0] rel_y_ff;

   // register port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= '0;
         height_ff <= '0;
         enable_ff <= 1'b1;
      end else if (csr_wr) begin
         unique case (paddr[3:2])
            REG_WIDTH:  width_ff  <= pwdata[13:0];
            REG_HEIGHT: height_ff <= pwdata[13:0];
            REG_ENABLE: enable_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_WIDTH:  prdata = {18'd0, width_ff};
         REG_HEIGHT: prdata = {18'd0, height_ff};
         REG_ENABLE: prdata = {31'd0, enable_ff};
         default:    prdata = '0;
      endcase
   end

   // event handshake
   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (accept) begin
         busy_ff <= 1'b1;
      end else if (tail.valid) begin
         busy_ff <= 1'b0;
      end
   end

   // inject a fresh search token at the head of the chain
   always_comb begin
      tok_chain[0]           = '0;
      tok_chain[0].valid     = accept;
      tok_chain[0].op        = req_opcode;
      tok_chain[0].id        = req_contact_id;
   end

   for (genvar k = 0; k < MAX_TOUCHES; k++) begin : g_cell
      tcst_cell #(
         .CELL_IDX(k)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .tok_in (tok_chain[k]),
         .tok_out(tok_chain[k+1]),
         .wr     (wr)
      );
   end

   assign tail = tok_chain[MAX_TOUCHES];

   tcst_scale u_scale_x (
      .clock  (clock),
      .load   (accept),
      .pos    (req_pos_x),
      .delta  (req_delta_x),
      .extent (width_ff),
      .abs_val(abs_x),
      .rel_val(rel_x)
   );

   tcst_scale u_scale_y (
      .clock  (clock),
      .load   (accept),
      .pos    (req_pos_y),
      .delta  (req_delta_y),
      .extent (height_ff),
      .abs_val(abs_y),
      .rel_val(rel_y)
   );

   // resolve the search once the token leaves the last cell
   always_comb begin
      found  = 1'b0;
      slot   = '0;
      wr     = '0;
      wr.id  = tail.id;
      unique case (tail.op)
         OP_DOWN: begin
            priority if (tail.hit) begin
               found = 1'b1;
               slot  = tail.hit_idx;
            end else if (tail.free_seen) begin
               found  = 1'b1;
               slot   = tail.free_idx;
               wr.en  = 1'b1;
               wr.set = 1'b1;
               wr.idx = tail.free_idx;
            end else begin
               found = 1'b0;
            end
         end
         OP_MOTION: begin
            found = tail.hit;
            slot  = tail.hit ? tail.hit_idx : '0;
         end
         OP_UP, OP_CANCEL: begin
            found  = tail.hit;
            slot   = tail.hit ? tail.hit_idx : '0;
            wr.en  = tail.hit;
            wr.set = 1'b0;
            wr.idx = tail.hit_idx;
         end
      endcase
      // drop the update unless this is a live, enabled transfer
      if (!tail.valid || !enable_ff) begin
         wr.en = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= tail.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (tail.valid) begin
         if (enable_ff) begin
            accepted_ff <= 1'b1;
            kind_ff     <= tail.op;
            found_ff    <= found;
            slot_ff     <= 5'(slot);
            abs_x_ff    <= abs_x;
            abs_y_ff    <= abs_y;
            rel_x_ff    <= rel_x;
            rel_y_ff    <= rel_y;
         end else begin
            accepted_ff <= 1'b0;
            kind_ff     <= '0;
            found_ff    <= 1'b0;
            slot_ff     <= '0;
            abs_x_ff    <= '0;
            abs_y_ff    <= '0;
            rel_x_ff    <= '0;
            rel_y_ff    <= '0;
         end
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_accepted   = accepted_ff;
   assign rsp_event_kind = kind_ff;
   assign rsp_slot_found = found_ff;
   assign rsp_slot_index = slot_ff;
   assign rsp_abs_x      = abs_x_ff;
   assign rsp_abs_y      = abs_y_ff;
   assign rsp_rel_x      = rel_x_ff;
   assign rsp_rel_y      = rel_y_ff;

endmodule

// ----- hw/rtl/tcst_cell.sv -----
// One slot of the contact table plus one stage of the search chain.
// Depends on tcst_pkg for the token and update types.
module tcst_cell #(
   parameter int CELL_IDX = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  tcst_pkg::tok_type tok_in,
   output tcst_pkg::tok_type tok_out,
   input  tcst_pkg::wr_type  wr
);
   import tcst_pkg::*;

   localparam logic [SLOT_W-1:0] MY_IDX = SLOT_W'(CELL_IDX);

   logic [ID_W-1:0] slot_id_ff;
   logic [ID_W-1:0] slot_id_in;
   logic            used_ff;
   logic            used_in;
   tok_type         tok_ff;
   tok_type         tok_in_next;
   logic            wr_here;

   always_comb begin
      tok_in_next = tok_in;
      // lowest matching slot wins
      if (!tok_in.hit && used_ff && (slot_id_ff == tok_in.id)) begin
         tok_in_next.hit     = 1'b1;
         tok_in_next.hit_idx = MY_IDX;
      end
      if (!tok_in.free_seen && !used_ff) begin
         tok_in_next.free_seen = 1'b1;
         tok_in_next.free_idx  = MY_IDX;
      end
   end

   assign wr_here = wr.en && (wr.idx == MY_IDX);

   always_comb begin
      used_in    = used_ff;
      slot_id_in = slot_id_ff;
      if (wr_here) begin
         used_in    = wr.set;
         slot_id_in = wr.set ? wr.id : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
         tok_ff  <= '0;
      end else begin
         used_ff <= used_in;
         tok_ff  <= tok_in_next;
      end
   end

   always_ff @(posedge clock) begin
      slot_id_ff <= slot_id_in;
   end

   assign tok_out = tok_ff;

endmodule

// ----- hw/rtl/tcst_scale.sv -----
// Scales one axis of normalized position and delta to pixels.
// Standalone; products are registered at load, sign fixed on the way out.
module tcst_scale (
   input  logic               clock,
   input  logic               load,
   input  logic        [15:0] pos,
   input  logic signed [17:0] delta,
   input  logic        [13:0] extent,
   output logic        [13:0] abs_val,
   output logic signed [15:0] rel_val
);

   logic [17:0] delta_u;
   logic [17:0] dmag;
   logic [29:0] abs_prod_ff;
   logic [29:0] abs_prod_in;
   logic [31:0] rel_prod_ff;
   logic [31:0] rel_prod_in;
   logic        neg_ff;
   logic [15:0] rel_q;

   assign delta_u     = unsigned'(delta);
   assign dmag        = delta_u[17] ? (18'd0 - delta_u) : delta_u;
   assign abs_prod_in = 30'(pos) * 30'(extent);
   assign rel_prod_in = 32'(dmag) * 32'(extent);

   always_ff @(posedge clock) begin
      if (load) begin
         abs_prod_ff <= abs_prod_in;
         rel_prod_ff <= rel_prod_in;
         neg_ff      <= delta_u[17];
      end
   end

   // magnitude stays below 2^15, so the negate never wraps
   assign rel_q   = rel_prod_ff[31:16];
   assign abs_val = abs_prod_ff[29:16];
   assign rel_val = signed'(neg_ff ? (16'd0 - rel_q) : rel_q);

endmodule

// ----- hw/rtl/tcst_checker.sv -----
// Port-level checks for the touch contact slot tracker, bound to the core.
// Depends only on the core's port names.
module tcst_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_strobe,
   input logic               rsp_accepted,
   input logic [1:0]         rsp_event_kind,
   input logic               rsp_slot_found,
   input logic [4:0]         rsp_slot_index,
   input logic [13:0]        rsp_abs_x,
   input logic [13:0]        rsp_abs_y,
   input logic signed [15:0] rsp_rel_x,
   input logic signed [15:0] rsp_rel_y
);

   // a taken event keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after transfer");

   // busy ends exactly when the result is shown
   a_fall_strobe: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("busy dropped without a result");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (!busy && $past(busy)))
      else $error("result outside an event");

   a_disabled_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_accepted) |->
         (rsp_event_kind == 2'd0 && !rsp_slot_found && rsp_slot_index == 5'd0 &&
          rsp_abs_x == 14'd0 && rsp_abs_y == 14'd0 &&
          rsp_rel_x == 16'sd0 && rsp_rel_y == 16'sd0))
      else $error("ignored event carries data");

   a_miss_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_slot_found) |-> (rsp_slot_index == 5'd0))
      else $error("slot index set on a miss");

endmodule

bind touch_contact_slot_tracker_core tcst_checker u_tcst_checker (.*);

// ----- tb/tb.sv -----
// Self-checking testbench for touch_contact_slot_tracker_core.
// Predicts every event report from its own copy of the slot table and the
// window registers; depends on tcst_pkg and the core RTL.
module tb;
   import tcst_pkg::*;

   localparam int SLOTS = 10;
   localparam int POOL_N = 14;
   localparam logic [1:0] REG_NONE = 2'd3;

   typedef struct packed {
      logic               accepted;
      logic [1:0]         event_kind;
      logic               slot_found;
      logic [4:0]         slot_index;
      logic [13:0]        abs_x;
      logic [13:0]        abs_y;
      logic signed [15:0] rel_x;
      logic signed [15:0] rel_y;
   } touch_report_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_opcode = OP_DOWN;
   logic [63:0]        req_contact_id = '0;
   logic [15:0]        req_pos_x = '0;
   logic [15:0]        req_pos_y = '0;
   logic signed [17:0] req_delta_x = '0;
   logic signed [17:0] req_delta_y = '0;
   logic               rsp_strobe;
   logic               rsp_accepted;
   logic [1:0]         rsp_event_kind;
   logic               rsp_slot_found;
   logic [4:0]         rsp_slot_index;
   logic [13:0]        rsp_abs_x;
   logic [13:0]        rsp_abs_y;
   logic signed [15:0] rsp_rel_x;
   logic signed [15:0] rsp_rel_y;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [3:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   // predictor state
   logic [63:0]   tbl_id [SLOTS];
   logic          tbl_used [SLOTS];
   logic [13:0]   cfg_width = '0;
   logic [13:0]   cfg_height = '0;
   logic          cfg_enable = 1'b1;

   touch_report_type pending_reports [$];
   logic [63:0]   id_pool [POOL_N];
   int            n_fail = 0;

   touch_contact_slot_tracker_core #(.MAX_TOUCHES(SLOTS)) i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_contact_id(req_contact_id),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y),
      .req_delta_x(req_delta_x), .req_delta_y(req_delta_y),
      .rsp_strobe(rsp_strobe), .rsp_accepted(rsp_accepted),
      .rsp_event_kind(rsp_event_kind), .rsp_slot_found(rsp_slot_found),
      .rsp_slot_index(rsp_slot_index), .rsp_abs_x(rsp_abs_x),
      .rsp_abs_y(rsp_abs_y), .rsp_rel_x(rsp_rel_x), .rsp_rel_y(rsp_rel_y),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

   // signed Q1.16 movement times extent, truncated toward zero
   function automatic logic signed [15:0] scale_move(logic signed [17:0] d,
                                                     logic [13:0] extent);
      logic        neg;
      logic [17:0] mag;
      logic [31:0] prod;
      logic [15:0] q;
      neg  = d[17];
      mag  = neg ? (18'd0 - d) : d;
      prod = mag * extent;
      q    = prod[31:16];
      return neg ? (16'd0 - q) : q;
   endfunction

   function automatic int find_slot(logic [63:0] id);
      for (int i = 0; i < SLOTS; i++) begin
         if (tbl_used[i] && tbl_id[i] == id) return i;
      end
      return -1;
   endfunction

   function automatic touch_report_type predict_report(logic [1:0] op, logic [63:0] id,
         logic [15:0] px, logic [15:0] py, logic signed [17:0] dx,
         logic signed [17:0] dy);
      touch_report_type r;
      int            slot;
      logic [29:0]   prod_x;
      logic [29:0]   prod_y;
      r = '0;
      if (!cfg_enable) return r;
      slot = find_slot(id);
      case (op)
         OP_DOWN: begin
            if (slot < 0) begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (slot < 0 && !tbl_used[i]) begin
                     slot = i;
                     tbl_used[i] = 1'b1;
                     tbl_id[i] = id;
                  end
               end
            end
         end
         OP_MOTION: ;
         default: begin
            if (slot >= 0) begin
               tbl_used[slot] = 1'b0;
               tbl_id[slot] = '0;
            end
         end
      endcase
      prod_x       = px * cfg_width;
      prod_y       = py * cfg_height;
      r.accepted   = 1'b1;
      r.event_kind = op;
      r.slot_found = (slot >= 0);
      r.slot_index = (slot >= 0) ? slot[4:0] : 5'd0;
      r.abs_x      = prod_x[29:16];
      r.abs_y      = prod_y[29:16];
      r.rel_x      = scale_move(dx, cfg_width);
      r.rel_y      = scale_move(dy, cfg_height);
      return r;
   endfunction

   function automatic void check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         n_fail++;
      end
   endfunction

   always @(posedge clock) begin
      touch_report_type e;
      if (!reset && rsp_strobe) begin
         if (pending_reports.size() == 0) begin
            $error("report with no event outstanding");
            n_fail++;
         end else begin
            e = pending_reports.pop_front();
            check_field("rsp_accepted", e.accepted, rsp_accepted);
            check_field("rsp_event_kind", e.event_kind, rsp_event_kind);
            check_field("rsp_slot_found", e.slot_found, rsp_slot_found);
            check_field("rsp_slot_index", e.slot_index, rsp_slot_index);
            check_field("rsp_abs_x", e.abs_x, rsp_abs_x);
            check_field("rsp_abs_y", e.abs_y, rsp_abs_y);
            check_field("rsp_rel_x", e.rel_x, rsp_rel_x);
            check_field("rsp_rel_y", e.rel_y, rsp_rel_y);
         end
      end
   end

   // leaves start high; the caller lowers it or sends the next event
   task automatic send_event(logic [1:0] op, logic [63:0] id, logic [15:0] px,
         logic [15:0] py, logic signed [17:0] dx, logic signed [17:0] dy);
      start          <= 1'b1;
      req_opcode     <= op;
      req_contact_id <= id;
      req_pos_x      <= px;
      req_pos_y      <= py;
      req_delta_x    <= dx;
      req_delta_y    <= dy;
      do @(posedge clock); while (busy);
      pending_reports.push_back(predict_report(op, id, px, py, dx, dy));
   endtask

   task automatic drain_events();
      start <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_WIDTH:  cfg_width = value[13:0];
         REG_HEIGHT: cfg_height = value[13:0];
         REG_ENABLE: cfg_enable = value[0];
         default: ;
      endcase
   endtask

   task automatic csr_read_check(logic [1:0] idx);
      logic [31:0] exp_v;
      case (idx)
         REG_WIDTH:  exp_v = {18'd0, cfg_width};
         REG_HEIGHT: exp_v = {18'd0, cfg_height};
         default:    exp_v = {31'd0, cfg_enable};
      endcase
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (prdata !== exp_v) begin
         $error("prdata reg %0d: expected %0d, got %0d", idx, exp_v, prdata);
         n_fail++;
      end
   endtask

   task automatic set_window(logic [13:0] w, logic [13:0] h, logic en);
      drain_events();
      // junk in the upper bits must be masked off
      csr_write(REG_WIDTH, {$urandom} << 14 | w);
      csr_write(REG_HEIGHT, {$urandom} << 14 | h);
      csr_write(REG_ENABLE, {$urandom} << 1 | en);
   endtask

   task automatic test_registers();
      csr_read_check(REG_WIDTH);
      csr_read_check(REG_HEIGHT);
      csr_read_check(REG_ENABLE);
      csr_write(REG_NONE, 32'hffff_ffff);
      set_window(14'd16383, 14'd16383, 1'b1);
      csr_read_check(REG_WIDTH);
      csr_read_check(REG_HEIGHT);
      csr_read_check(REG_ENABLE);
   endtask

   task automatic test_field_extremes();
      send_event(OP_DOWN, 64'hffff_ffff_ffff_ffff, 16'hffff, 16'hffff,
                 18'sh1ffff, 18'sh1ffff);
      send_event(OP_MOTION, 64'hffff_ffff_ffff_ffff, 16'h0000, 16'h0000,
                 -18'sd131072, -18'sd131072);
      send_event(OP_DOWN, 64'd0, 16'h8000, 16'h0001, 18'sd65536, -18'sd65536);
      send_event(OP_MOTION, 64'd0, 16'h0001, 16'h8000, -18'sd1, 18'sd1);
      send_event(OP_UP, 64'hffff_ffff_ffff_ffff, 16'h5555, 16'haaaa,
                 18'sh15555, 18'sh2aaaa);
      send_event(OP_CANCEL, 64'd0, 16'haaaa, 16'h5555, 18'sh2aaaa, 18'sh15555);
   endtask

   task automatic test_table_full();
      set_window(14'd1, 14'd8191, 1'b1);
      for (int i = 0; i < SLOTS; i++)
         send_event(OP_DOWN, 64'h100 + i, 16'($urandom), 16'($urandom),
                    18'($urandom), 18'($urandom));
      // no slot left for a new contact, but a known one keeps its slot
      send_event(OP_DOWN, 64'h200, 16'hffff, 16'hffff, 18'sd3, -18'sd3);
      send_event(OP_DOWN, 64'h104, 16'h1234, 16'h4321, 18'sd0, 18'sd0);
      // freed middle slot becomes the lowest free one
      send_event(OP_UP, 64'h103, 16'h0, 16'h0, 18'sd0, 18'sd0);
      send_event(OP_DOWN, 64'h200, 16'h0, 16'h0, 18'sd0, 18'sd0);
      for (int i = 0; i < SLOTS; i++)
         send_event((i % 2) ? OP_CANCEL : OP_UP, (i == 3) ? 64'h200 : 64'h100 + i,
                    16'($urandom), 16'($urandom), 18'($urandom), 18'($urandom));
   endtask

   task automatic test_unknown_contact();
      // freed slots hold id zero, which must not match
      send_event(OP_MOTION, 64'd0, 16'hffff, 16'h0, 18'sh1ffff, 18'sh20000);
      send_event(OP_UP, 64'h0123_4567_89ab_cdef, 16'h0, 16'hffff, 18'sd1, 18'sd1);
      send_event(OP_CANCEL, 64'd0, 16'h7fff, 16'h7fff, -18'sd1, -18'sd1);
   endtask

   task automatic test_disabled();
      set_window(14'd16383, 14'd16383, 1'b0);
      send_event(OP_DOWN, 64'h55, 16'hffff, 16'hffff, 18'sd65536, 18'sd65536);
      send_event(OP_UP, 64'h55, 16'hffff, 16'hffff, 18'sd65536, 18'sd65536);
      set_window(14'd16383, 14'd16383, 1'b1);
      send_event(OP_MOTION, 64'h55, 16'hffff, 16'hffff, 18'sd65536, 18'sd65536);
   endtask

   function automatic logic signed [17:0] rand_move();
      case ($urandom_range(0, 3))
         0: return 18'($urandom);
         1: return 18'($urandom_range(0, 131072) - 65536);
         2: return ($urandom_range(0, 1)) ? 18'sh1ffff : -18'sd131072;
         default: return 18'($urandom_range(0, 64) - 32);
      endcase
   endfunction

   task automatic test_random_traffic(int n_items);
      int          burst;
      int          gap;
      logic [1:0]  op;
      logic [63:0] id;
      logic [15:0] px;
      logic [15:0] py;
      burst = $urandom_range(1, 12);
      for (int n = 0; n < n_items; n++) begin
         if ($urandom_range(0, 99) < 80) begin
            case ($urandom_range(0, 19))
               0, 1, 2, 3, 4, 5, 6: op = OP_DOWN;
               7, 8, 9, 10, 11, 12, 13: op = OP_MOTION;
               14, 15, 16: op = OP_UP;
               default: op = OP_CANCEL;
            endcase
            id = id_pool[$urandom_range(0, POOL_N - 1)];
         end else begin
            op = 2'($urandom);
            id = {$urandom, $urandom};
         end
         px = $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 16'hffff : 16'h0)
                                        : 16'($urandom);
         py = 16'($urandom);
         send_event(op, id, px, py, rand_move(), rand_move());
         burst--;
         if (burst == 0) begin
            burst = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if ($urandom_range(0, 39) == 0) begin
               drain_events();
            end else if (gap != 0) begin
               start <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   endtask

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         tbl_id[i] = '0;
         tbl_used[i] = 1'b0;
      end
      id_pool[0] = 64'd0;
      id_pool[1] = 64'hffff_ffff_ffff_ffff;
      for (int i = 2; i < POOL_N; i++) id_pool[i] = {$urandom, $urandom};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_registers();
      test_field_extremes();
      test_table_full();
      test_unknown_contact();
      test_disabled();

      set_window(14'd16383, 14'd16383, 1'b1);
      test_random_traffic(170);
      set_window(14'd0, 14'd0, 1'b1);
      test_random_traffic(150);
      set_window(14'd1, 14'd16383, 1'b1);
      test_random_traffic(150);
      set_window(14'd16383, 14'd0, 1'b1);
      test_random_traffic(150);
      set_window(14'd1920, 14'd1080, 1'b1);
      test_random_traffic(150);
      set_window(14'd0, 14'd0, 1'b0);
      set_window(14'($urandom), 14'($urandom), 1'b0);
      test_random_traffic(30);
      for (int p = 0; p < 2; p++) begin
         set_window(14'($urandom), 14'($urandom), 1'b1);
         test_random_traffic(175);
      end

      drain_events();
      repeat (SLOTS + 4) @(posedge clock);
      if (n_fail == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
